/* design/ccdc_pkg.sv */
`timescale 1ns / 1ps

package ccdc_pkg;

    // Register stages from the request port to the response register.
    localparam int PIPE_STAGES = 8;
    // Stages inside each converter; the last top-level stage zeroes and holds.
    localparam int SUB_STAGES  = PIPE_STAGES - 1;

    typedef logic [SUB_STAGES-1:0] t_stage_en;

    localparam logic [17:0] DAYS_PER_ERA   = 18'd146097;
    localparam logic [22:0] EPOCH_SHIFT    = 23'd730425;   // 5 eras less the March offset
    localparam logic [8:0]  YEARS_PER_ERA  = 9'd400;
    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [17:0] DAYS_PER_4Y    = 18'd1460;
    localparam logic [17:0] DAYS_PER_100Y  = 18'd36524;
    localparam logic [17:0] LAST_ERA_DAY   = 18'd146096;

    // Reciprocals: exact floor quotients over the operand ranges used.
    localparam logic [13:0] RECIP_400      = 14'd10486;    // >> 22, year < 2^14
    localparam logic [22:0] RECIP_ERA      = 23'd7525902;  // >> 40, day < 2^22
    localparam logic [18:0] RECIP_1460_365 = 19'd367720;   // >> 29 for 1460, >> 27 for 365

    localparam logic signed [22:0] MIN_DAYS = -23'sd730119;
    localparam logic signed [22:0] MAX_DAYS = 23'sd2921939;

    localparam logic [13:0] MAX_YEAR  = 14'd9999;
    localparam logic [3:0]  MAX_MONTH = 4'd12;

    localparam logic [3:0]  MP_JAN = 4'd10;                // first March-based month of next year

    // Days before a March-based month (March is 0).
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] res;
        unique case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    // March-based month that holds a day of the shifted year.
    function automatic logic [3:0] month_of_day(input logic [8:0] doy);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (doy >= month_start(4'(k))) begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt;
    endfunction

    // Whole centuries inside an era year (yoe / 100 for yoe < 400).
    function automatic logic [1:0] centuries(input logic [8:0] yoe);
        logic [1:0] cnt;
        cnt = 2'd0;
        if (yoe >= 9'd100) cnt = cnt + 2'd1;
        if (yoe >= 9'd200) cnt = cnt + 2'd1;
        if (yoe >= 9'd300) cnt = cnt + 2'd1;
        return cnt;
    endfunction

endpackage

/* design/ccdc_chan_if.sv */
`timescale 1ns / 1ps

interface ccdc_req_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [22:0] day_count;

    modport source (output valid, func, year, month, day, day_count, input ready);
    modport sink   (input valid, func, year, month, day, day_count, output ready);
endinterface

interface ccdc_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [22:0] days_out;
    logic [13:0]        year_out;
    logic [3:0]         month_out;
    logic [4:0]         day_out;
    logic               bad_input;

    modport source (output valid, days_out, year_out, month_out, day_out, bad_input,
                    input ready);
    modport sink   (input valid, days_out, year_out, month_out, day_out, bad_input,
                    output ready);
endinterface

/* design/ccdc_to_days.sv */
`timescale 1ns / 1ps

module ccdc_to_days (
    input  logic                     i_clk,
    input  ccdc_pkg::t_stage_en      i_en,
    input  logic [13:0]              i_year,
    input  logic [3:0]               i_month,
    input  logic [4:0]               i_day,
    output logic signed [22:0]       o_days
);

    logic        early;
    logic [13:0] n_yp0, r_yp0;
    logic [8:0]  n_doy0, r_doy0;
    logic [3:0]  mp;

    logic [27:0] era_prod;
    logic [13:0] r_yp1;
    logic [5:0]  r_era1;
    logic [8:0]  r_doy1;

    logic [13:0] era_years;
    logic [8:0]  n_yoe2, r_yoe2;
    logic [5:0]  r_era2;
    logic [8:0]  r_doy2;

    logic [17:0] n_doe3, r_doe3;
    logic [22:0] n_erad3, r_erad3;

    logic [22:0] n_days4, r_days4;
    logic [22:0] r_days5, r_days6;

    // Stage 0: shift to a March-based year and month.
    always_comb begin
        early  = (i_month <= 4'd2);
        n_yp0  = i_year - 14'(early);
        mp     = early ? i_month + 4'd9 : i_month - 4'd3;
        n_doy0 = ccdc_pkg::month_start(mp) + 9'(i_day) - 9'd1;
    end

    // Stage 1: era = yp / 400.
    assign era_prod = 28'(r_yp0) * 28'(ccdc_pkg::RECIP_400);

    // Stage 2: year of era.
    assign era_years = 14'(14'(r_era1) * 14'(ccdc_pkg::YEARS_PER_ERA));
    assign n_yoe2    = 9'(r_yp1 - era_years);

    // Stage 3: day of era and era base.
    assign n_doe3  = 18'(r_yoe2) * 18'(ccdc_pkg::DAYS_PER_YEAR) + 18'(r_yoe2[8:2])
                   - 18'(ccdc_pkg::centuries(r_yoe2)) + 18'(r_doy2);
    assign n_erad3 = 23'(r_era2) * 23'(ccdc_pkg::DAYS_PER_ERA);

    // Stage 4: rebase to the epoch.
    assign n_days4 = 23'(r_doe3) + r_erad3 - ccdc_pkg::EPOCH_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_yp0  <= n_yp0;
            r_doy0 <= n_doy0;
        end
        if (i_en[1]) begin
            r_yp1  <= r_yp0;
            r_era1 <= era_prod[27:22];
            r_doy1 <= r_doy0;
        end
        if (i_en[2]) begin
            r_yoe2 <= n_yoe2;
            r_era2 <= r_era1;
            r_doy2 <= r_doy1;
        end
        if (i_en[3]) begin
            r_doe3  <= n_doe3;
            r_erad3 <= n_erad3;
        end
        if (i_en[4]) begin
            r_days4 <= n_days4;
        end
        if (i_en[5]) begin
            r_days5 <= r_days4;
        end
        if (i_en[6]) begin
            r_days6 <= r_days5;
        end
    end

    assign o_days = $signed(r_days6);

endmodule

/* design/ccdc_to_date.sv */
`timescale 1ns / 1ps

module ccdc_to_date (
    input  logic                     i_clk,
    input  ccdc_pkg::t_stage_en      i_en,
    input  logic signed [22:0]       i_day_count,
    output logic [13:0]              o_year,
    output logic [3:0]               o_month,
    output logic [4:0]               o_day
);

    logic [22:0] shifted;
    logic [21:0] r_dep0;

    logic [44:0] era_prod;
    logic [21:0] r_dep1;
    logic [4:0]  r_era1;

    logic [21:0] era_base;
    logic [17:0] n_doe2, r_doe2;
    logic [4:0]  r_era2;

    logic [36:0] q4_prod;
    logic [2:0]  n_c100_3, r_c100_3;
    logic [7:0]  r_q4_3;
    logic        r_last3;
    logic [17:0] r_doe3;
    logic [4:0]  r_era3;

    logic [17:0] adj;
    logic [36:0] yoe_prod;
    logic [8:0]  r_yoe4;
    logic [17:0] r_doe4;
    logic [4:0]  r_era4;

    logic [17:0] year_days;
    logic [8:0]  n_doy5, r_doy5;
    logic [13:0] n_yp5, r_yp5;

    logic [3:0]  mp;
    logic [8:0]  day_full;
    logic [3:0]  n_month6, r_month6;
    logic [4:0]  n_day6, r_day6;
    logic [13:0] n_year6, r_year6;

    // Stage 0: count from 0000-03-01.
    assign shifted = 23'(i_day_count) + ccdc_pkg::EPOCH_SHIFT;

    // Stage 1: era = dep / 146097.
    assign era_prod = 45'(r_dep0) * 45'(ccdc_pkg::RECIP_ERA);

    // Stage 2: day of era.
    assign era_base = 22'(22'(r_era1) * 22'(ccdc_pkg::DAYS_PER_ERA));
    assign n_doe2   = 18'(r_dep1 - era_base);

    // Stage 3: leap corrections.
    assign q4_prod = 37'(r_doe2) * 37'(ccdc_pkg::RECIP_1460_365);
    always_comb begin
        n_c100_3 = 3'd0;
        for (int k = 1; k <= 4; k++) begin
            if (r_doe2 >= 18'(k * 36524)) begin
                n_c100_3 = n_c100_3 + 3'd1;
            end
        end
    end

    // Stage 4: year of era.
    assign adj      = r_doe3 - 18'(r_q4_3) + 18'(r_c100_3) - 18'(r_last3);
    assign yoe_prod = 37'(adj) * 37'(ccdc_pkg::RECIP_1460_365);

    // Stage 5: day of March-based year.
    assign year_days = 18'(r_yoe4) * 18'(ccdc_pkg::DAYS_PER_YEAR) + 18'(r_yoe4[8:2])
                     - 18'(ccdc_pkg::centuries(r_yoe4));
    assign n_doy5    = 9'(r_doe4 - year_days);
    assign n_yp5     = 14'(r_yoe4) + 14'(14'(r_era4) * 14'(ccdc_pkg::YEARS_PER_ERA));

    // Stage 6: split into month and day, move back to a January-based year.
    always_comb begin
        mp       = ccdc_pkg::month_of_day(r_doy5);
        day_full = r_doy5 - ccdc_pkg::month_start(mp) + 9'd1;
        n_day6   = day_full[4:0];
        n_month6 = (mp < ccdc_pkg::MP_JAN) ? mp + 4'd3 : mp - 4'd9;
        n_year6  = r_yp5 + 14'(mp >= ccdc_pkg::MP_JAN);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dep0 <= shifted[21:0];
        end
        if (i_en[1]) begin
            r_dep1 <= r_dep0;
            r_era1 <= era_prod[44:40];
        end
        if (i_en[2]) begin
            r_doe2 <= n_doe2;
            r_era2 <= r_era1;
        end
        if (i_en[3]) begin
            r_q4_3   <= q4_prod[36:29];
            r_c100_3 <= n_c100_3;
            r_last3  <= (r_doe2 == ccdc_pkg::LAST_ERA_DAY);
            r_doe3   <= r_doe2;
            r_era3   <= r_era2;
        end
        if (i_en[4]) begin
            r_yoe4 <= yoe_prod[35:27];
            r_doe4 <= r_doe3;
            r_era4 <= r_era3;
        end
        if (i_en[5]) begin
            r_doy5 <= n_doy5;
            r_yp5  <= n_yp5;
        end
        if (i_en[6]) begin
            r_year6  <= n_year6;
            r_month6 <= n_month6;
            r_day6   <= n_day6;
        end
    end

    assign o_year  = r_year6;
    assign o_month = r_month6;
    assign o_day   = r_day6;

endmodule

/* design/civil_date_day_count_converter.sv */
`timescale 1ns / 1ps

// Gregorian date <-> day count converter, epoch 2000-01-01, years 1..9999.
// func 0 turns year/month/day into a signed day count (days past a month's
// end roll into the next month); func 1 turns a day count into a date. An
// out-of-range request returns bad_input with all other fields zero, and
// fields of the unselected function are zero. Both conversions run in an
// eight-stage pipeline (one reciprocal multiply or one add/compare level per
// stage); a new request is taken every cycle while the response is not
// stalled. Each stage advances when it is empty or when the stage after it
// advances, so bubbles close up behind a stalled response and requests keep
// entering until the pipeline is full.
module civil_date_day_count_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccdc_req_if.sink      i_req,
    ccdc_rsp_if.source    o_rsp
);

    localparam int LAST = ccdc_pkg::PIPE_STAGES - 1;

    logic [ccdc_pkg::PIPE_STAGES-1:0] r_valid;
    logic [ccdc_pkg::PIPE_STAGES-1:0] n_valid;
    logic [ccdc_pkg::PIPE_STAGES-1:0] stage_en;

    logic [LAST-1:0] r_func;
    logic [LAST-1:0] r_bad;

    logic date_bad;
    logic days_bad;
    logic n_bad0;

    logic signed [22:0] days_res;
    logic [13:0]        year_res;
    logic [3:0]         month_res;
    logic [4:0]         day_res;

    logic signed [22:0] r_days_out;
    logic [13:0]        r_year_out;
    logic [3:0]         r_month_out;
    logic [4:0]         r_day_out;
    logic               r_bad_out;

    logic keep_days;
    logic keep_date;

    // Advance a stage when it is empty or its successor advances.
    always_comb begin
        stage_en[LAST] = !r_valid[LAST] || o_rsp.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k + 1];
        end
    end

    // Hold off requests while in reset.
    assign i_req.ready = stage_en[0] && i_rst_n;

    always_comb begin
        n_valid = r_valid;
        if (stage_en[0]) begin
            n_valid[0] = i_req.valid;
        end
        for (int k = 1; k < ccdc_pkg::PIPE_STAGES; k++) begin
            if (stage_en[k]) begin
                n_valid[k] = r_valid[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Range checks on the raw request.
    assign date_bad = (i_req.year == 14'd0) || (i_req.year > ccdc_pkg::MAX_YEAR)
                   || (i_req.month == 4'd0) || (i_req.month > ccdc_pkg::MAX_MONTH)
                   || (i_req.day == 5'd0);
    assign days_bad = (i_req.day_count < ccdc_pkg::MIN_DAYS)
                   || (i_req.day_count > ccdc_pkg::MAX_DAYS);
    assign n_bad0   = i_req.func ? days_bad : date_bad;

    // Carry the selector and the error flag alongside the datapath.
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_func[0] <= i_req.func;
            r_bad[0]  <= n_bad0;
        end
        for (int k = 1; k < LAST; k++) begin
            if (stage_en[k]) begin
                r_func[k] <= r_func[k - 1];
                r_bad[k]  <= r_bad[k - 1];
            end
        end
    end

    ccdc_to_days u_to_days (
        .i_clk   (i_clk),
        .i_en    (stage_en[LAST-1:0]),
        .i_year  (i_req.year),
        .i_month (i_req.month),
        .i_day   (i_req.day),
        .o_days  (days_res)
    );

    ccdc_to_date u_to_date (
        .i_clk       (i_clk),
        .i_en        (stage_en[LAST-1:0]),
        .i_day_count (i_req.day_count),
        .o_year      (year_res),
        .o_month     (month_res),
        .o_day       (day_res)
    );

    // Response register: drop the unselected result, zero on error.
    assign keep_days = !r_func[LAST-1] && !r_bad[LAST-1];
    assign keep_date =  r_func[LAST-1] && !r_bad[LAST-1];

    always_ff @(posedge i_clk) begin
        if (stage_en[LAST]) begin
            r_days_out  <= keep_days ? days_res  : '0;
            r_year_out  <= keep_date ? year_res  : '0;
            r_month_out <= keep_date ? month_res : '0;
            r_day_out   <= keep_date ? day_res   : '0;
            r_bad_out   <= r_bad[LAST-1];
        end
    end

    assign o_rsp.valid     = r_valid[LAST];
    assign o_rsp.days_out  = r_days_out;
    assign o_rsp.year_out  = r_year_out;
    assign o_rsp.month_out = r_month_out;
    assign o_rsp.day_out   = r_day_out;
    assign o_rsp.bad_input = r_bad_out;

endmodule

/* tb/tb_civil_date_day_count_converter.sv */
`timescale 1ns / 1ps

module tb_civil_date_day_count_converter;

    localparam logic FUNC_TO_DAYS = 1'b0;
    localparam logic FUNC_TO_DATE = 1'b1;

    localparam int RANDOM_ITEMS   = 800;
    localparam int QUIET_ITEMS    = 150;
    localparam int LONG_HOLD      = 60;
    localparam int STALL_LIMIT    = 2000;

    // Calendar constants for the expected-value computation.
    localparam int ERA_DAYS        = 146097;
    localparam int ERAS_TO_EPOCH   = 5;
    localparam int MARCH_SHIFT     = 60;
    localparam int FIRST_DAY_COUNT = -730119;
    localparam int LAST_DAY_COUNT  = 2921939;
    localparam int LAST_YEAR       = 9999;

    typedef struct packed {
        logic signed [22:0] days;
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic               bad;
    } t_conversion;

    // Expected conversions in request order, checked against each response.
    class t_date_scoreboard;
        t_conversion pending_conversions[$];
        int          errors = 0;

        // Compute the civil conversion of one request.
        function t_conversion civil_conversion(logic fn, logic [13:0] y, logic [3:0] m,
                                               logic [4:0] d, logic signed [22:0] ed);
            t_conversion res;
            int iy, im, id, ie;
            int yp, era, yoe, mp, doy, doe, cnt, dep, yy, mm, dd;
            res = '0;
            iy = y;
            im = m;
            id = d;
            ie = ed;
            if (fn == FUNC_TO_DAYS) begin
                if (iy < 1 || iy > LAST_YEAR || im < 1 || im > 12 || id < 1) begin
                    res.bad = 1'b1;
                end else begin
                    // January and February belong to the previous March-based year.
                    yp  = iy - ((im <= 2) ? 1 : 0);
                    era = yp / 400;
                    yoe = yp - 400 * era;
                    mp  = (im <= 2) ? im + 9 : im - 3;
                    doy = (153 * mp + 2) / 5 + id - 1;
                    doe = 365 * yoe + yoe / 4 - yoe / 100 + doy;
                    cnt = doe + ERA_DAYS * era - ERAS_TO_EPOCH * ERA_DAYS + MARCH_SHIFT;
                    res.days = cnt[22:0];
                end
            end else begin
                if (ie < FIRST_DAY_COUNT || ie > LAST_DAY_COUNT) begin
                    res.bad = 1'b1;
                end else begin
                    dep = ie + ERAS_TO_EPOCH * ERA_DAYS - MARCH_SHIFT;
                    era = dep / ERA_DAYS;
                    doe = dep - ERA_DAYS * era;
                    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
                    yp  = yoe + 400 * era;
                    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
                    mp  = (5 * doy + 2) / 153;
                    dd  = doy - (153 * mp + 2) / 5 + 1;
                    mm  = (mp < 10) ? mp + 3 : mp - 9;
                    yy  = yp + ((mm <= 2) ? 1 : 0);
                    res.year  = yy[13:0];
                    res.month = mm[3:0];
                    res.day   = dd[4:0];
                end
            end
            return res;
        endfunction

        function void note_request(logic fn, logic [13:0] y, logic [3:0] m,
                                   logic [4:0] d, logic signed [22:0] ed);
            pending_conversions.push_back(civil_conversion(fn, y, m, d, ed));
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_response(t_conversion got);
            t_conversion want;
            if (pending_conversions.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %p", $time, got);
            end else begin
                want = pending_conversions.pop_front();
                compare_field("days_out",  want.days,  got.days);
                compare_field("year_out",  want.year,  got.year);
                compare_field("month_out", want.month, got.month);
                compare_field("day_out",   want.day,   got.day);
                compare_field("bad_input", want.bad,   got.bad);
            end
        endfunction

        function int pending();
            return pending_conversions.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ccdc_req_if req_if ();
    ccdc_rsp_if rsp_if ();

    civil_date_day_count_converter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_date_scoreboard board = new();

    // Set by the sender: quiet drops all idling, hold_rsp_long asks the
    // receiver for one long stall while requests keep coming.
    bit quiet         = 1'b0;
    bit hold_rsp_long = 1'b0;
    int idle_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one request and hold it until the block takes it. Idle first at random.
    task automatic send_request(logic fn, logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                logic signed [22:0] ed);
        int gap;
        if (!quiet && !hold_rsp_long && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= fn;
        req_if.year      <= y;
        req_if.month     <= m;
        req_if.day       <= d;
        req_if.day_count <= ed;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Receiver: random stalls, one long hold on request, none in the quiet tail.
    initial begin
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_rsp_long) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_rsp_long = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Note each accepted request, check each accepted response.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                board.note_request(req_if.func, req_if.year, req_if.month, req_if.day,
                                   req_if.day_count);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                board.check_response({rsp_if.days_out, rsp_if.year_out, rsp_if.month_out,
                                      rsp_if.day_out, rsp_if.bad_input});
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("tb_civil_date_day_count_converter NOT OK");
            $finish;
        end
    end

    initial begin
        logic               fn;
        logic [13:0]        y;
        logic [3:0]         m;
        logic [4:0]         d;
        logic signed [22:0] ed;
        int                 pick;

        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.func      <= FUNC_TO_DAYS;
        req_if.year      <= '0;
        req_if.month     <= '0;
        req_if.day       <= '0;
        req_if.day_count <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: range ends, leap days, month rollover, invalid inputs.
        send_request(FUNC_TO_DAYS, 14'd1,     4'd1,  5'd1,  '0);
        send_request(FUNC_TO_DAYS, 14'd9999,  4'd12, 5'd31, '0);
        send_request(FUNC_TO_DAYS, 14'd2000,  4'd1,  5'd1,  '0);
        send_request(FUNC_TO_DAYS, 14'd2000,  4'd2,  5'd29, '0);
        send_request(FUNC_TO_DAYS, 14'd1900,  4'd2,  5'd29, '0);
        send_request(FUNC_TO_DAYS, 14'd2000,  4'd2,  5'd31, '0);
        send_request(FUNC_TO_DAYS, 14'd2001,  4'd4,  5'd31, '0);
        send_request(FUNC_TO_DAYS, 14'd400,   4'd3,  5'd1,  '0);
        send_request(FUNC_TO_DAYS, 14'd0,     4'd6,  5'd15, '0);
        send_request(FUNC_TO_DAYS, 14'd10000, 4'd6,  5'd15, '0);
        send_request(FUNC_TO_DAYS, 14'd16383, 4'd15, 5'd31, '0);
        send_request(FUNC_TO_DAYS, 14'd1999,  4'd0,  5'd10, '0);
        send_request(FUNC_TO_DAYS, 14'd1999,  4'd13, 5'd10, '0);
        send_request(FUNC_TO_DAYS, 14'd1999,  4'd5,  5'd0,  '0);
        send_request(FUNC_TO_DATE, '0, '0, '0, 23'(FIRST_DAY_COUNT));
        send_request(FUNC_TO_DATE, '0, '0, '0, 23'(LAST_DAY_COUNT));
        send_request(FUNC_TO_DATE, '0, '0, '0, 23'(FIRST_DAY_COUNT - 1));
        send_request(FUNC_TO_DATE, '0, '0, '0, 23'(LAST_DAY_COUNT + 1));
        send_request(FUNC_TO_DATE, '0, '0, '0, 23'sd0);
        send_request(FUNC_TO_DATE, '0, '0, '0, -23'sd1);
        send_request(FUNC_TO_DATE, '0, '0, '0, 23'sd59);
        send_request(FUNC_TO_DATE, '0, '0, '0, 23'h400000);
        send_request(FUNC_TO_DATE, '0, '0, '0, 23'h3FFFFF);

        // Random: mostly valid requests near the range ends and across it,
        // the rest raw field values.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) hold_rsp_long = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            fn = 1'($urandom);
            y  = 14'($urandom);
            m  = 4'($urandom);
            d  = 5'($urandom);
            ed = 23'($urandom);
            if ($urandom_range(0, 7) != 0) begin
                pick = $urandom_range(0, 3);
                m    = 4'($urandom_range(1, 12));
                d    = 5'($urandom_range(1, 31));
                case (pick)
                    0: begin
                        y  = 14'($urandom_range(1, 30));
                        ed = 23'(int'($urandom_range(0, 20000)) + FIRST_DAY_COUNT);
                    end
                    1: begin
                        y  = 14'($urandom_range(LAST_YEAR - 30, LAST_YEAR));
                        ed = 23'(LAST_DAY_COUNT - int'($urandom_range(0, 20000)));
                    end
                    2: begin
                        y  = 14'($urandom_range(1960, 2040));
                        ed = 23'(int'($urandom_range(0, 30000)) - 15000);
                    end
                    default: begin
                        y  = 14'($urandom_range(1, LAST_YEAR));
                        ed = 23'(int'($urandom_range(0, LAST_DAY_COUNT - FIRST_DAY_COUNT))
                                 + FIRST_DAY_COUNT);
                    end
                endcase
            end
            send_request(fn, y, m, d, ed);
        end
        req_if.valid <= 1'b0;

        // Drain, then give stray responses a chance to show up.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (ccdc_pkg::PIPE_STAGES + 4) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_civil_date_day_count_converter OK");
        end else begin
            $display("tb_civil_date_day_count_converter NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
design/ccdc_pkg.sv
design/ccdc_chan_if.sv
design/ccdc_to_days.sv
design/ccdc_to_date.sv
design/civil_date_day_count_converter.sv
tb/tb_civil_date_day_count_converter.sv
